FILE: design/mbe_pkg.sv
// Shared types, constants and a helper function of the escape-time evaluator.
`default_nettype none

package mbe_pkg;

	localparam int FRAC_BITS_DEF  = 28;
	localparam int COORD_BITS_DEF = 12;
	localparam int NUM_CELLS_DEF  = 4;

	localparam int COORD_W = 12;
	localparam int ITER_W  = 16;
	localparam int Z_W     = 32;
	localparam int STEP_W  = 31;
	localparam int PROD_W  = 2 * Z_W;
	localparam int SCALE_W = COORD_W + STEP_W;
	localparam int ADDR_W  = 5;
	localparam int DATA_W  = 32;
	localparam int IDX_W   = 3;

	localparam logic [IDX_W-1:0] REG_ORIGIN_RE = 3'd0;
	localparam logic [IDX_W-1:0] REG_ORIGIN_IM = 3'd1;
	localparam logic [IDX_W-1:0] REG_STEP_RE   = 3'd2;
	localparam logic [IDX_W-1:0] REG_STEP_IM   = 3'd3;
	localparam logic [IDX_W-1:0] REG_MAX_ITER  = 3'd4;
	localparam logic [IDX_W-1:0] REG_MIN_DRAW  = 3'd5;

	localparam logic signed [Z_W-1:0]  ORIGIN_RST   = -32'sd536870912;
	localparam logic [STEP_W-1:0]      STEP_RST     = 31'd1048576;
	localparam logic [ITER_W-1:0]      MAX_ITER_RST = 16'd256;
	localparam logic [ITER_W-1:0]      MIN_DRAW_RST = 16'd10;

	localparam logic signed [PROD_W-1:0] S32_MAX = 64'sh0000_0000_7fff_ffff;
	localparam logic signed [PROD_W-1:0] S32_MIN = -64'sh0000_0000_8000_0000;

	typedef struct packed {
		logic signed [Z_W-1:0] origin_re;
		logic signed [Z_W-1:0] origin_im;
		logic [STEP_W-1:0]     step_re;
		logic [STEP_W-1:0]     step_im;
		logic [ITER_W-1:0]     max_iter;
		logic [ITER_W-1:0]     min_iter;
	} cfg_t;

	typedef struct packed {
		logic                  valid;
		logic                  done;
		logic                  draw;
		logic [ITER_W-1:0]     iter;
		logic signed [Z_W-1:0] zr;
		logic signed [Z_W-1:0] zi;
	} tok_t;

	function automatic logic signed [Z_W-1:0] sat_s32(input logic signed [PROD_W-1:0] v);
		logic signed [Z_W-1:0] r;
		if (v > S32_MAX) begin
			r = S32_MAX[Z_W-1:0];
		end else if (v < S32_MIN) begin
			r = S32_MIN[Z_W-1:0];
		end else begin
			r = v[Z_W-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: design/mbe_regs.sv
// Configuration register file behind the APB-style port.
`default_nettype none

module mbe_regs
	import mbe_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0]      prdata,
	output logic                   pready,
	output cfg_t                   cfg
);

	cfg_t             cfg_q;
	logic [IDX_W-1:0] idx;
	logic             wr_en;

	assign idx    = paddr[ADDR_W-1:2];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.origin_re <= ORIGIN_RST;
			cfg_q.origin_im <= ORIGIN_RST;
			cfg_q.step_re   <= STEP_RST;
			cfg_q.step_im   <= STEP_RST;
			cfg_q.max_iter  <= MAX_ITER_RST;
			cfg_q.min_iter  <= MIN_DRAW_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_ORIGIN_RE: cfg_q.origin_re <= pwdata;
				REG_ORIGIN_IM: cfg_q.origin_im <= pwdata;
				REG_STEP_RE:   cfg_q.step_re   <= pwdata[STEP_W-1:0];
				REG_STEP_IM:   cfg_q.step_im   <= pwdata[STEP_W-1:0];
				REG_MAX_ITER:  cfg_q.max_iter  <= pwdata[ITER_W-1:0];
				REG_MIN_DRAW:  cfg_q.min_iter  <= pwdata[ITER_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_ORIGIN_RE: prdata = cfg_q.origin_re;
			REG_ORIGIN_IM: prdata = cfg_q.origin_im;
			REG_STEP_RE:   prdata = {1'b0, cfg_q.step_re};
			REG_STEP_IM:   prdata = {1'b0, cfg_q.step_im};
			REG_MAX_ITER:  prdata = {{(DATA_W-ITER_W){1'b0}}, cfg_q.max_iter};
			REG_MIN_DRAW:  prdata = {{(DATA_W-ITER_W){1'b0}}, cfg_q.min_iter};
			default:       prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

FILE: design/mbe_coord.sv
// Two-stage mapping of a pixel to the complex point c.
`default_nettype none

module mbe_coord
	import mbe_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [COORD_W-1:0] px,
	input  wire logic [COORD_W-1:0] py,
	input  wire cfg_t               cfg,
	output logic                    valid_s2,
	output logic signed [Z_W-1:0]   c_re,
	output logic signed [Z_W-1:0]   c_im
);

	logic                  valid_s1;
	logic [SCALE_W-1:0]    prod_re_s1;
	logic [SCALE_W-1:0]    prod_im_s1;
	logic signed [Z_W-1:0] c_re_q;
	logic signed [Z_W-1:0] c_im_q;
	logic signed [PROD_W-1:0] sum_re;
	logic signed [PROD_W-1:0] sum_im;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= start;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			prod_re_s1 <= SCALE_W'(px) * SCALE_W'(cfg.step_re);
			prod_im_s1 <= SCALE_W'(py) * SCALE_W'(cfg.step_im);
		end
		if (valid_s1) begin
			c_re_q <= sat_s32(sum_re);
			c_im_q <= sat_s32(sum_im);
		end
	end

	always_comb begin
		sum_re = PROD_W'(cfg.origin_re) + $signed({{(PROD_W-SCALE_W){1'b0}}, prod_re_s1});
		sum_im = PROD_W'(cfg.origin_im) + $signed({{(PROD_W-SCALE_W){1'b0}}, prod_im_s1});
	end

	assign c_re = c_re_q;
	assign c_im = c_im_q;

endmodule

`default_nettype wire

FILE: design/mbe_cell.sv
// One iteration cell: squares z in its first stage, tests and updates it in its second.
`default_nettype none

module mbe_cell
	import mbe_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire tok_t                  tok_in,
	input  wire logic signed [Z_W-1:0] c_re,
	input  wire logic signed [Z_W-1:0] c_im,
	input  wire logic [ITER_W-1:0]     max_iter,
	input  wire logic [ITER_W-1:0]     min_iter,
	output tok_t                       tok_out
);

	localparam logic [PROD_W-1:0] LIMIT = PROD_W'(4) << FRAC_BITS;

	tok_t                     tok_s1;
	tok_t                     tok_s2;
	tok_t                     nxt;
	logic signed [PROD_W-1:0] sqr;
	logic signed [PROD_W-1:0] sqi;
	logic signed [PROD_W-1:0] crs;
	logic signed [PROD_W-1:0] sqr_s1;
	logic signed [PROD_W-1:0] sqi_s1;
	logic signed [PROD_W-1:0] crs_s1;
	logic [PROD_W-1:0]        mag;
	logic signed [PROD_W-1:0] rr;
	logic signed [Z_W-1:0]    nr;
	logic signed [Z_W-1:0]    ni;
	logic                     esc;

	always_comb begin
		sqr = tok_in.zr * tok_in.zr;
		sqi = tok_in.zi * tok_in.zi;
		crs = tok_in.zr * tok_in.zi;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s1 <= '0;
			tok_s2 <= '0;
		end else begin
			tok_s1 <= tok_in;
			tok_s2 <= nxt;
		end
	end

	always_ff @(posedge clk) begin
		sqr_s1 <= sqr;
		sqi_s1 <= sqi;
		crs_s1 <= crs;
	end

	always_comb begin
		mag = unsigned'(sqr_s1) + unsigned'(sqi_s1);
		esc = mag >= LIMIT;
		rr  = sqr_s1 - sqi_s1;
		nr  = sat_s32((rr >>> FRAC_BITS) + PROD_W'(c_re));
		ni  = sat_s32((crs_s1 >>> (FRAC_BITS - 1)) + PROD_W'(c_im));
		nxt = tok_s1;
		if (tok_s1.valid && !tok_s1.done) begin
			if (esc || (tok_s1.iter >= max_iter)) begin
				nxt.done = 1'b1;
				nxt.draw = esc && (tok_s1.iter >= min_iter);
			end else begin
				nxt.zr   = nr;
				nxt.zi   = ni;
				nxt.iter = tok_s1.iter + ITER_W'(1);
			end
		end
	end

	assign tok_out = tok_s2;

endmodule

`default_nettype wire

FILE: design/mandelbrot_escape_time_top.sv
// Top level of the Mandelbrot escape-time evaluator: ring of iteration cells.
//
//   channel  | handshake                      | payload
//   ---------+--------------------------------+------------------------------------
//   input    | in_valid / in_ready            | pixel_x, pixel_y
//   output   | out_valid / out_ready          | out_x, out_y, iterations, draw
//   config   | psel, penable, pwrite, pready  | paddr, pwdata, prdata
//
// One item is evaluated at a time. The pixel is first mapped to c, then the item circulates
// through the NUM_CELLS cells, one cell pass per iteration plus one that marks it finished,
// and it leaves only at the end of the ring, where its result is registered for the output;
// the next item can be accepted from the cycle in which that result becomes valid.
// Reset restores the defaults and empties the ring. A result waits in the output register;
// while it is held, a finished item laps the ring again.
`default_nettype none

module mandelbrot_escape_time_top
	import mbe_pkg::*;
#(
	parameter int FRAC_BITS  = FRAC_BITS_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int NUM_CELLS  = NUM_CELLS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [COORD_W-1:0] pixel_x,
	input  wire logic [COORD_W-1:0] pixel_y,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [COORD_W-1:0]      out_x,
	output logic [COORD_W-1:0]      out_y,
	output logic [ITER_W-1:0]       iterations,
	output logic                    draw,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [ADDR_W-1:0]  paddr,
	input  wire logic [DATA_W-1:0]  pwdata,
	output logic [DATA_W-1:0]       prdata,
	output logic                    pready
);

	localparam int CB = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;
	localparam logic [COORD_W-1:0] CMASK = COORD_W'((64'd1 << CB) - 64'd1);

	cfg_t                  cfg;
	tok_t                  ring [NUM_CELLS+1];
	tok_t                  feed;
	logic                  in_fire;
	logic                  take;
	logic                  finish;
	logic                  inject;
	logic signed [Z_W-1:0] c_re;
	logic signed [Z_W-1:0] c_im;
	logic [COORD_W-1:0]    px_q;
	logic [COORD_W-1:0]    py_q;
	logic                  busy_q;
	logic                  out_valid_q;
	logic [COORD_W-1:0]    out_x_q;
	logic [COORD_W-1:0]    out_y_q;
	logic [ITER_W-1:0]     iter_q;
	logic                  draw_q;
	logic [NUM_CELLS:0]    live;

	mbe_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign in_ready = !busy_q;
	assign in_fire  = in_valid && in_ready;

	mbe_coord u_coord (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (in_fire),
		.px       (pixel_x & CMASK),
		.py       (pixel_y & CMASK),
		.cfg      (cfg),
		.valid_s2 (inject),
		.c_re     (c_re),
		.c_im     (c_im)
	);

	assign take   = !out_valid_q || out_ready;
	assign finish = ring[NUM_CELLS].valid && ring[NUM_CELLS].done && take;

	always_comb begin
		feed = '0;
		if (inject) begin
			feed.valid = 1'b1;
		end else if (ring[NUM_CELLS].valid && !finish) begin
			feed = ring[NUM_CELLS];
		end
	end

	assign ring[0] = feed;

	for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
		mbe_cell #(
			.FRAC_BITS (FRAC_BITS)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.tok_in   (ring[k]),
			.c_re     (c_re),
			.c_im     (c_im),
			.max_iter (cfg.max_iter),
			.min_iter (cfg.min_iter),
			.tok_out  (ring[k+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_fire) begin
				busy_q <= 1'b1;
			end else if (finish) begin
				busy_q <= 1'b0;
			end
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			px_q <= pixel_x & CMASK;
			py_q <= pixel_y & CMASK;
		end
		if (finish) begin
			out_x_q <= px_q;
			out_y_q <= py_q;
			iter_q  <= ring[NUM_CELLS].iter;
			draw_q  <= ring[NUM_CELLS].draw;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_x      = out_x_q;
	assign out_y      = out_y_q;
	assign iterations = iter_q;
	assign draw       = draw_q;

	always_comb begin
		live[0] = inject;
		for (int k = 1; k <= NUM_CELLS; k++) begin
			live[k] = ring[k].valid;
		end
	end

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !in_ready)
		else $error("block took a second item while one was in flight");

	a_single_item: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(live))
		else $error("more than one item is circulating in the ring");

	a_iter_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (iterations <= cfg.max_iter))
		else $error("iteration count exceeds the limit");

	a_draw_min: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && draw) |-> (iterations >= cfg.min_iter))
		else $error("pixel drawn below the minimum iteration count");

endmodule

`default_nettype wire
